// ===== src/pfc_pkg.sv =====
// Shared types and constants for the pixel format converter.
// Holds the format codes, register map, payload structs and channel widening helpers.
// No dependencies.
package pfc_pkg;

    // Pixel format codes (code seven behaves as ARGB8888)
    localparam logic [2:0] FMT_RGB24    = 3'd0;
    localparam logic [2:0] FMT_ARGB8888 = 3'd1;
    localparam logic [2:0] FMT_RGBA8888 = 3'd2;
    localparam logic [2:0] FMT_RGB565   = 3'd3;
    localparam logic [2:0] FMT_ARGB1555 = 3'd4;
    localparam logic [2:0] FMT_RGBA4444 = 3'd5;
    localparam logic [2:0] FMT_GRAY8    = 3'd6;

    // Register map, indexed by paddr[3:2]
    localparam int unsigned APB_ADDR_W = 4;
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
    localparam logic [1:0] REG_EXPAND_MODE   = 2'd2;

    localparam logic [2:0] SOURCE_FORMAT_RESET = FMT_ARGB8888;
    localparam logic [2:0] TARGET_FORMAT_RESET = FMT_ARGB8888;
    localparam logic       EXPAND_MODE_RESET   = 1'b0;

    localparam logic EXPAND_ZERO_FILL = 1'b0;
    localparam logic EXPAND_SCALE     = 1'b1;

    // Luma weights in Q16
    localparam logic [15:0] GRAY_R_WEIGHT = 16'd19595;
    localparam logic [15:0] GRAY_G_WEIGHT = 16'd38470;
    localparam logic [15:0] GRAY_B_WEIGHT = 16'd7471;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic        run_end_in;
    } t_pfc_in;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        run_end_out;
    } t_pfc_out;

    typedef struct packed {
        logic [2:0] source_format;
        logic [2:0] target_format;
        logic       expand_mode;
    } t_pfc_cfg;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pfc_argb;

    // floor(x * 255 / 31) for a 5-bit channel
    localparam logic [7:0] SCALE5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    function automatic logic [7:0] widen5(input logic [4:0] x, input logic mode);
        return (mode == EXPAND_SCALE) ? SCALE5[x] : {x, 3'b000};
    endfunction

    // floor(x * 255 / 63) = 4x + floor(x / 21), the second term by comparison
    function automatic logic [7:0] widen6(input logic [5:0] x, input logic mode);
        logic [1:0] frac;
        frac = (x >= 6'd63) ? 2'd3 : (x >= 6'd42) ? 2'd2 : (x >= 6'd21) ? 2'd1 : 2'd0;
        return (mode == EXPAND_SCALE) ? ({x, 2'b00} + {6'd0, frac}) : {x, 2'b00};
    endfunction

    // x * 255 / 15 is exactly x * 17, i.e. the nibble repeated
    function automatic logic [7:0] widen4(input logic [3:0] x, input logic mode);
        return (mode == EXPAND_SCALE) ? {x, x} : {x, 4'b0000};
    endfunction

endpackage

// ===== src/pfc_cfg_regs.sv =====
// Configuration register file of the pixel format converter, on an APB-style port.
// Depends on pfc_pkg for the register map and reset values.
module pfc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output pfc_pkg::t_pfc_cfg               o_cfg
);
    import pfc_pkg::*;

    logic [2:0] r_source_format;
    logic [2:0] r_target_format;
    logic       r_expand_mode;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format <= SOURCE_FORMAT_RESET;
            r_target_format <= TARGET_FORMAT_RESET;
            r_expand_mode   <= EXPAND_MODE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SOURCE_FORMAT: r_source_format <= pwdata[2:0];
                REG_TARGET_FORMAT: r_target_format <= pwdata[2:0];
                REG_EXPAND_MODE:   r_expand_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SOURCE_FORMAT: prdata = {29'd0, r_source_format};
            REG_TARGET_FORMAT: prdata = {29'd0, r_target_format};
            REG_EXPAND_MODE:   prdata = {31'd0, r_expand_mode};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{source_format: r_source_format,
                     target_format: r_target_format,
                     expand_mode:   r_expand_mode};

endmodule

// ===== src/pfc_decode.sv =====
// Source side of the pixel format converter: unpacks a pixel into A, R, G, B bytes.
// Depends on pfc_pkg for format codes and the widening helpers.
module pfc_decode (
    input  logic [31:0]           i_pixel,
    input  logic [2:0]            i_source_format,
    input  logic                  i_expand_mode,
    output pfc_pkg::t_pfc_argb    o_argb
);
    import pfc_pkg::*;

    always_comb begin
        case (i_source_format)
            FMT_RGB24: begin
                o_argb = '{a: 8'hFF, r: i_pixel[7:0], g: i_pixel[15:8], b: i_pixel[23:16]};
            end
            FMT_RGBA8888: begin
                o_argb = '{a: i_pixel[31:24], r: i_pixel[7:0],
                           g: i_pixel[15:8],  b: i_pixel[23:16]};
            end
            FMT_RGB565: begin
                o_argb = '{a: 8'hFF,
                           r: widen5(i_pixel[15:11], i_expand_mode),
                           g: widen6(i_pixel[10:5],  i_expand_mode),
                           b: widen5(i_pixel[4:0],   i_expand_mode)};
            end
            FMT_ARGB1555: begin
                // A single alpha bit always opens to fully opaque or fully clear.
                o_argb = '{a: {8{i_pixel[15]}},
                           r: widen5(i_pixel[14:10], i_expand_mode),
                           g: widen5(i_pixel[9:5],   i_expand_mode),
                           b: widen5(i_pixel[4:0],   i_expand_mode)};
            end
            FMT_RGBA4444: begin
                o_argb = '{a: widen4(i_pixel[3:0],   i_expand_mode),
                           r: widen4(i_pixel[15:12], i_expand_mode),
                           g: widen4(i_pixel[11:8],  i_expand_mode),
                           b: widen4(i_pixel[7:4],   i_expand_mode)};
            end
            FMT_GRAY8: begin
                o_argb = '{a: 8'hFF, r: i_pixel[7:0], g: i_pixel[7:0], b: i_pixel[7:0]};
            end
            default: begin
                o_argb = '{a: i_pixel[7:0],   r: i_pixel[15:8],
                           g: i_pixel[23:16], b: i_pixel[31:24]};
            end
        endcase
    end

endmodule

// ===== src/pfc_encode.sv =====
// Destination side of the pixel format converter: packs A, R, G, B bytes into a pixel.
// Depends on pfc_pkg for format codes and the luma weights.
module pfc_encode (
    input  pfc_pkg::t_pfc_argb    i_argb,
    input  logic [2:0]            i_target_format,
    output logic [31:0]           o_pixel
);
    import pfc_pkg::*;

    logic [23:0] gray_r;
    logic [23:0] gray_g;
    logic [23:0] gray_b;
    logic [25:0] gray_sum;

    // The weights add up to 65536, so the sum stays below 2^24.
    assign gray_r   = 24'(i_argb.r) * 24'(GRAY_R_WEIGHT);
    assign gray_g   = 24'(i_argb.g) * 24'(GRAY_G_WEIGHT);
    assign gray_b   = 24'(i_argb.b) * 24'(GRAY_B_WEIGHT);
    assign gray_sum = 26'(gray_r) + 26'(gray_g) + 26'(gray_b);

    always_comb begin
        case (i_target_format)
            FMT_RGB24: begin
                o_pixel = {8'd0, i_argb.b, i_argb.g, i_argb.r};
            end
            FMT_RGBA8888: begin
                o_pixel = {i_argb.a, i_argb.b, i_argb.g, i_argb.r};
            end
            FMT_RGB565: begin
                o_pixel = {16'd0, i_argb.r[7:3], i_argb.g[7:2], i_argb.b[7:3]};
            end
            FMT_ARGB1555: begin
                o_pixel = {16'd0, i_argb.a[7], i_argb.r[7:3], i_argb.g[7:3], i_argb.b[7:3]};
            end
            FMT_RGBA4444: begin
                o_pixel = {16'd0, i_argb.r[7:4], i_argb.g[7:4], i_argb.b[7:4], i_argb.a[7:4]};
            end
            FMT_GRAY8: begin
                o_pixel = {24'd0, gray_sum[23:16]};
            end
            default: begin
                o_pixel = {i_argb.b, i_argb.g, i_argb.r, i_argb.a};
            end
        endcase
    end

endmodule

// ===== src/pixel_format_converter_unit.sv =====
// Top level of the pixel format converter: request pipeline and result register.
// Depends on pfc_pkg, pfc_cfg_regs, pfc_decode and pfc_encode.
//
// The converter takes one pixel request in every clock cycle unless its input
// stall is raised, and hands back one converted pixel for each, in order, with
// run_end copied alongside. An accepted request is held in the input register,
// passes through the decode and encode logic and lands in the result register,
// from which it is offered. The single combinational path between the two
// registers has as its longest leg the three constant multiplications of the
// gray encoder. Both stages advance together unless the result register is
// full and stalled; the input stall then rises only while the input register
// is also occupied, so a waiting result never holds back the request behind
// it. Source format, target format and expand mode are written over the
// APB-style port (byte addresses 0, 4 and 8) and must only be changed while no
// request is in flight.
module pixel_format_converter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  pfc_pkg::t_pfc_in                i_in_data,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output pfc_pkg::t_pfc_out               o_out_data,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pfc_pkg::*;

    t_pfc_cfg   cfg;
    t_pfc_argb  argb;
    logic [31:0] enc_pixel;

    logic       r_in_valid;
    t_pfc_in    r_in_data;
    logic       r_out_valid;
    t_pfc_out   r_out_data;

    logic       out_free;
    logic       in_take;

    pfc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The result register can take a new value when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    // The input register can take a request when empty or when it moves on.
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    pfc_decode u_decode (
        .i_pixel         (r_in_data.pixel_in),
        .i_source_format (cfg.source_format),
        .i_expand_mode   (cfg.expand_mode),
        .o_argb          (argb)
    );

    pfc_encode u_encode (
        .i_argb          (argb),
        .i_target_format (cfg.target_format),
        .o_pixel         (enc_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_out_data <= '{pixel_out: enc_pixel, run_end_out: r_in_data.run_end_in};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
